>>> rtl/ssbhm_pkg.sv
// ----------------------------------------------------------------------------
// ssbhm_pkg
// Shared constants and build-time tap generation for the SSB Hilbert
// modulator: Hamming-windowed Hilbert taps in Q1.15, computed in Q30.
// ----------------------------------------------------------------------------
package ssbhm_pkg;

  localparam int TAP_COUNT_DEF = 63;
  localparam int TAP_COUNT_MIN = 3;
  localparam int TAP_COUNT_MAX = 255;
  localparam int SAMPLE_W      = 16;
  localparam int PROD_W        = 2 * SAMPLE_W;

  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint unsigned ONE_Q30 = 64'd1073741824;
  localparam longint unsigned HAM_A   = 64'd579820585;
  localparam longint unsigned HAM_B   = 64'd493921239;

  // shift-subtract division, build time only
  function automatic longint unsigned ssbhm_udiv(longint unsigned num,
                                                 longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], num[i]};
      if (r >= den) begin
        r    = r - den;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // cos(2*pi*k/d) in Q30, d even
  function automatic longint ssbhm_cos_turn(longint unsigned k, longint unsigned d);
    longint unsigned kk;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    bit              neg;
    kk  = k;
    neg = 1'b0;
    if (kk * 2 > d) kk = d - kk;
    if (kk * 4 > d) begin
      kk  = (d >> 1) - kk;
      neg = 1'b1;
    end
    x    = ssbhm_udiv(2 * PI_Q30 * kk + (d >> 1), d);
    x2   = (x * x + (ONE_Q30 >> 1)) >> 30;
    term = ONE_Q30;
    sum  = longint'(ONE_Q30);
    for (int j = 1; j <= 10; j++) begin
      term = ssbhm_udiv((term * x2) >> 30,
                        longint'(2 * j - 1) * longint'(2 * j));
      if (j % 2 == 1) sum = sum - longint'(term);
      else            sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    return neg ? -sum : sum;
  endfunction

  // tap k of an nt-tap filter (nt odd)
  function automatic logic signed [SAMPLE_W-1:0] ssbhm_tap(int nt, int k);
    int              n;
    int              an;
    longint          c;
    longint unsigned mag;
    longint unsigned prod;
    longint unsigned w;
    longint unsigned den;
    longint unsigned t;
    n  = k - (nt - 1) / 2;
    an = (n < 0) ? -n : n;
    if (an % 2 == 0) return '0;
    c    = ssbhm_cos_turn(longint'(k), longint'(nt - 1));
    mag  = longint'((c < 0) ? -c : c);
    prod = (HAM_B * mag + (ONE_Q30 >> 1)) >> 30;
    w    = (c < 0) ? HAM_A + prod : HAM_A - prod;
    den  = PI_Q30 * longint'(an);
    t    = ssbhm_udiv(w * 64'd65536 + (den >> 1), den);
    return (n < 0) ? -SAMPLE_W'(t) : SAMPLE_W'(t);
  endfunction

endpackage

>>> rtl/ssb_hilbert_modulator_core.sv
// ----------------------------------------------------------------------------
// ssb_hilbert_modulator_core
// SSB phasing modulator: real Q1.15 audio in, complex baseband out. I is the
// input delayed by half the filter length, Q is a Hamming-windowed Hilbert
// FIR output, rounded and saturated, negated for lower sideband.
// ----------------------------------------------------------------------------
// Takes one audio sample per clock while in_stall is low and gives one I/Q
// pair per sample, in order. P is the number of odd-offset taps of the
// effective N-tap filter, where N = TAP_COUNT|1 clamped to 3..255:
// P = (N+1)/2 when (N-1)/2 is odd, else (N-1)/2 (P = 32 at 63 taps). The
// stages are one multiply stage, one registered adder-tree level per halving
// of P, and a round/saturate output register. Only odd-offset taps get a
// multiplier. Stall propagates stage by stage, so empty stages keep filling
// while the output is held. The delay line clears on reset; no warm-up pass
// is needed.
module ssb_hilbert_modulator_core #(
  parameter int TAP_COUNT = ssbhm_pkg::TAP_COUNT_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic                                 cfg_sideband_select,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [ssbhm_pkg::SAMPLE_W-1:0] in_audio_sample,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [ssbhm_pkg::SAMPLE_W-1:0] out_in_phase,
  output logic signed [ssbhm_pkg::SAMPLE_W-1:0] out_quadrature
);
  import ssbhm_pkg::*;

  localparam int N_ODD  = TAP_COUNT | 1;
  localparam int N_TAPS = (N_ODD > TAP_COUNT_MAX) ? TAP_COUNT_MAX :
                          ((N_ODD < TAP_COUNT_MIN) ? TAP_COUNT_MIN : N_ODD);
  localparam int MID    = (N_TAPS - 1) / 2;
  localparam int K0     = (MID % 2 == 1) ? 0 : 1;
  localparam int P      = (N_TAPS - 1 - K0) / 2 + 1;
  localparam int L      = $clog2(P);
  localparam int PW     = 1 << L;
  localparam int ACC_W  = PROD_W + L;
  localparam int S      = L + 2;

  localparam logic signed [ACC_W:0]    RND_HALF = (ACC_W+1)'(16384);
  localparam logic signed [ACC_W:0]    Q_MAX    = (ACC_W+1)'(32767);
  localparam logic signed [ACC_W:0]    Q_MIN    = -(ACC_W+1)'(32768);
  localparam logic signed [SAMPLE_W-1:0] S_MAX  = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] S_MIN  = 16'sh8000;

  logic                       sb_r;
  logic signed [SAMPLE_W-1:0] dl_r   [N_TAPS-1];
  logic signed [SAMPLE_W-1:0] win    [N_TAPS];
  logic signed [PROD_W-1:0]   prod_r [P];
  logic signed [ACC_W-1:0]    tree_r [L][PW/2];
  logic signed [ACC_W-1:0]    node   [L+1][PW];
  logic signed [SAMPLE_W-1:0] ip_r   [S];
  logic signed [SAMPLE_W-1:0] q_r;
  logic [S-1:0]               valid_r;
  logic [S-1:0]               en;
  logic                       in_acc;
  logic signed [ACC_W:0]      rnd_sum;
  logic signed [ACC_W:0]      rnd_q;
  logic signed [SAMPLE_W-1:0] sat_q;
  logic signed [SAMPLE_W-1:0] q_nxt;

  // config
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_r <= 1'b0;
    end else if (cfg_valid) begin
      sb_r <= cfg_sideband_select;
    end
  end

  // stage enables, back to front
  always_comb begin
    en[S-1] = !valid_r[S-1] || !out_stall;
    for (int i = S - 2; i >= 0; i--) begin
      en[i] = !valid_r[i] || en[i+1];
    end
  end

  assign in_stall = !en[0];
  assign in_acc   = in_valid && en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (en[0]) valid_r[0] <= in_valid;
      for (int i = 1; i < S; i++) begin
        if (en[i]) valid_r[i] <= valid_r[i-1];
      end
    end
  end

  // delay line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N_TAPS - 1; i++) dl_r[i] <= '0;
    end else if (in_acc) begin
      dl_r[0] <= in_audio_sample;
      for (int i = 1; i < N_TAPS - 1; i++) dl_r[i] <= dl_r[i-1];
    end
  end

  always_comb begin
    win[0] = in_audio_sample;
    for (int i = 1; i < N_TAPS; i++) win[i] = dl_r[i-1];
  end

  // stage 0: odd-offset tap products
  for (genvar gp = 0; gp < P; gp++) begin : g_tap
    localparam int                         GK   = K0 + 2 * gp;
    localparam logic signed [SAMPLE_W-1:0] TapC = ssbhm_tap(N_TAPS, GK);
    always_ff @(posedge clk) begin
      if (en[0]) prod_r[gp] <= PROD_W'(win[GK]) * PROD_W'(TapC);
    end
  end

  // adder tree view
  always_comb begin
    for (int j = 0; j < PW; j++) begin
      if (j < P) node[0][j] = ACC_W'(prod_r[j]);
      else       node[0][j] = '0;
    end
    for (int l = 1; l <= L; l++) begin
      for (int j = 0; j < PW; j++) begin
        if (j < PW / 2) node[l][j] = tree_r[l-1][j];
        else            node[l][j] = '0;
      end
    end
  end

  // stages 1..L: one tree level each
  always_ff @(posedge clk) begin
    for (int l = 0; l < L; l++) begin
      if (en[l+1]) begin
        for (int j = 0; j < PW / 2; j++) begin
          if (j < (PW >> (l + 1))) tree_r[l][j] <= node[l][2*j] + node[l][2*j+1];
          else                     tree_r[l][j] <= '0;
        end
      end
    end
  end

  // in-phase rides along
  always_ff @(posedge clk) begin
    if (en[0]) ip_r[0] <= win[MID];
    for (int i = 1; i < S; i++) begin
      if (en[i]) ip_r[i] <= ip_r[i-1];
    end
  end

  // output stage: round, saturate, sideband
  always_comb begin
    rnd_sum = {node[L][0][ACC_W-1], node[L][0]} + RND_HALF;
    rnd_q   = rnd_sum >>> 15;
    if (rnd_q > Q_MAX)      sat_q = S_MAX;
    else if (rnd_q < Q_MIN) sat_q = S_MIN;
    else                    sat_q = rnd_q[SAMPLE_W-1:0];
    if (sb_r) q_nxt = (sat_q == S_MIN) ? S_MAX : -sat_q;
    else      q_nxt = sat_q;
  end

  always_ff @(posedge clk) begin
    if (en[S-1]) q_r <= q_nxt;
  end

  assign out_valid      = valid_r[S-1];
  assign out_in_phase   = ip_r[S-1];
  assign out_quadrature = q_r;

endmodule

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for ssb_hilbert_modulator_core. A local Hilbert FIR
// predictor (own tap table, exact accumulator, round/saturate, sideband
// negation) scores every I/Q result against the accepted audio requests,
// under random input gaps, random output stalls and a long output hold-off.
// ----------------------------------------------------------------------------
module testbench;

  import ssbhm_pkg::*;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    sample_t in_phase;
    sample_t quadrature;
  } iq_t;

  typedef enum int {RX_FLOW, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;
  typedef enum int {SRC_UNIFORM, SRC_EXTREME, SRC_QUIET, SRC_SQUARE} src_style_t;

  localparam int TAPS_CFG = TAP_COUNT_DEF;
  localparam int NTAP = ((TAPS_CFG | 1) > TAP_COUNT_MAX) ? TAP_COUNT_MAX :
                        (((TAPS_CFG | 1) < TAP_COUNT_MIN) ? TAP_COUNT_MIN : (TAPS_CFG | 1));
  localparam int MID         = (NTAP - 1) / 2;
  localparam int NPROD       = (NTAP + 1) / 2;
  localparam int LAT         = $clog2(NPROD) + 2;
  localparam int HOLD_CYCLES = 300;
  localparam int LIMIT       = 400000;

  localparam longint unsigned Q30_PI   = 64'd3373259426;
  localparam longint unsigned Q30_ONE  = 64'd1073741824;
  localparam longint unsigned Q30_HAMA = 64'd579820585;
  localparam longint unsigned Q30_HAMB = 64'd493921239;

  localparam sample_t SAMPLE_MAX = 16'sh7FFF;
  localparam sample_t SAMPLE_MIN = 16'sh8000;

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    cfg_valid = 1'b0;
  logic    cfg_ready;
  logic    cfg_sideband_select = 1'b0;
  logic    in_valid = 1'b0;
  logic    in_stall;
  sample_t in_audio_sample = '0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  sample_t out_in_phase;
  sample_t out_quadrature;

  int      tap_rom [NTAP];
  sample_t history [NTAP];
  bit      sideband_lsb = 1'b0;
  iq_t     pending_iq [$];

  bit          sq_high = 1'b0;
  int          sq_left = 0;
  bit          hold_off_req = 1'b0;
  int          hold_left = 0;
  int unsigned mismatches = 0;
  int unsigned samples_sent = 0;
  int unsigned results_checked = 0;
  int unsigned cycles = 0;

  ssb_hilbert_modulator_core #(
    .TAP_COUNT(TAPS_CFG)
  ) uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_sideband_select (cfg_sideband_select),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_audio_sample     (in_audio_sample),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_in_phase        (out_in_phase),
    .out_quadrature      (out_quadrature)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // cos(2*pi*k/d) in Q30, folded to the first quadrant, truncating Taylor steps
  function automatic longint cos_q30(input int unsigned k, input int unsigned d);
    longint unsigned a;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    bit              flip;
    a    = k;
    flip = 1'b0;
    if (a * 2 > d) a = d - a;
    if (a * 4 > d) begin
      a    = d / 2 - a;
      flip = 1'b1;
    end
    x    = (2 * Q30_PI * a + d / 2) / d;
    x2   = (x * x + (Q30_ONE >> 1)) >> 30;
    term = Q30_ONE;
    sum  = longint'(Q30_ONE);
    for (longint unsigned j = 1; j <= 10; j++) begin
      term = ((term * x2) >> 30) / ((2 * j - 1) * (2 * j));
      if (j[0]) sum -= longint'(term);
      else      sum += longint'(term);
    end
    if (sum < 0) sum = 0;
    return flip ? -sum : sum;
  endfunction

  function automatic void build_tap_rom();
    int              n;
    int              an;
    longint          c;
    longint unsigned mag;
    longint unsigned prod;
    longint unsigned w;
    longint unsigned den;
    longint unsigned t;
    for (int k = 0; k < NTAP; k++) begin
      n  = k - MID;
      an = (n < 0) ? -n : n;
      tap_rom[k] = 0;
      history[k] = '0;
      if (an % 2 == 1) begin
        c    = cos_q30(k, NTAP - 1);
        mag  = (c < 0) ? -c : c;
        prod = (Q30_HAMB * mag + (Q30_ONE >> 1)) >> 30;
        w    = (c < 0) ? Q30_HAMA + prod : Q30_HAMA - prod;
        den  = Q30_PI * longint'(an);
        t    = (w * 64'd65536 + den / 2) / den;
        tap_rom[k] = (n < 0) ? -int'(t) : int'(t);
      end
    end
  endfunction

  // shifts the sample into the history and returns the I/Q pair it produces
  function automatic iq_t hilbert_iq_predict(input sample_t s);
    iq_t    r;
    longint acc;
    longint q;
    for (int k = NTAP - 1; k > 0; k--) history[k] = history[k - 1];
    history[0] = s;
    acc = 0;
    for (int k = 0; k < NTAP; k++) acc += longint'(tap_rom[k]) * longint'(history[k]);
    q = (acc + 64'sd16384) >>> 15;
    if (q > 32767) q = 32767;
    else if (q < -32768) q = -32768;
    if (sideband_lsb) q = (q == -32768) ? 32767 : -q;
    r.in_phase   = history[MID];
    r.quadrature = sample_t'(q);
    return r;
  endfunction

  function automatic sample_t next_random_sample(input src_style_t style);
    case (style)
      SRC_UNIFORM: return sample_t'($urandom);
      SRC_EXTREME: begin
        case ($urandom_range(0, 4))
          0:       return SAMPLE_MAX;
          1:       return SAMPLE_MIN;
          2:       return '0;
          3:       return -16'sd1;
          default: return 16'sd1;
        endcase
      end
      SRC_QUIET: return sample_t'(int'($urandom_range(0, 511)) - 256);
      default: begin
        if (sq_left == 0) begin
          sq_left = $urandom_range(4, 40);
          sq_high = ~sq_high;
        end
        sq_left--;
        return sq_high ? SAMPLE_MAX - sample_t'($urandom_range(0, 15))
                       : SAMPLE_MIN + sample_t'($urandom_range(0, 15));
      end
    endcase
  endfunction

  task automatic send_sample(input sample_t s);
    in_valid        <= 1'b1;
    in_audio_sample <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_iq.push_back(hilbert_iq_predict(s));
    samples_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_iq.size() != 0) @(posedge clk);
    repeat (LAT + 4) @(posedge clk);
  endtask

  task automatic write_sideband(input bit lsb);
    wait_idle();
    cfg_valid           <= 1'b1;
    cfg_sideband_select <= lsb;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid    <= 1'b0;
    sideband_lsb = lsb;
  endtask

  task automatic test_directed_edges();
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample('0);
    send_sample(16'sd1);
    send_sample(-16'sd1);
    send_sample(16'sh5555);
    send_sample(16'shAAAA);
    send_sample(16'sd16384);
    send_sample(-16'sd16384);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
  endtask

  // step pattern aligned on the filter center drives the sum past full scale
  task automatic test_saturation();
    sample_t hi;
    sample_t lo;
    for (int pol = 0; pol < 2; pol++) begin
      hi = pol ? SAMPLE_MIN : SAMPLE_MAX;
      lo = pol ? SAMPLE_MAX : SAMPLE_MIN;
      repeat (4) send_sample(hi);
      send_sample('0);
      repeat (4) send_sample(lo);
      repeat ((MID > 4) ? MID - 4 : 0) send_sample('0);
    end
  endtask

  task automatic test_random_stream(input int count);
    int         left;
    int         burst;
    src_style_t style;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 48);
      if (burst > left) burst = left;
      style = src_style_t'($urandom_range(0, 3));
      repeat (burst) send_sample(next_random_sample(style));
      left -= burst;
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  endtask

  // output held off long enough that the pipeline fills and stalls requests
  task automatic test_backpressure();
    wait_idle();
    hold_off_req = 1'b1;
    repeat (2 * NPROD + 40) send_sample(next_random_sample(SRC_UNIFORM));
    wait_idle();
  endtask

  initial begin : rx_stall_pattern
    int       seg_left;
    rx_mode_t seg_mode;
    seg_left = 0;
    seg_mode = RX_FLOW;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_left    = HOLD_CYCLES;
        hold_off_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(16, 160);
          seg_mode = rx_mode_t'($urandom_range(0, 3));
        end
        seg_left--;
        case (seg_mode)
          RX_FLOW:  out_stall <= 1'b0;
          RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:  out_stall <= ~out_stall;
        endcase
      end
    end
  end

  always @(posedge clk) begin : check_iq
    iq_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_iq.size() == 0) begin
        $error("unexpected result: in_phase %0d quadrature %0d", out_in_phase, out_quadrature);
        mismatches++;
      end else begin
        want = pending_iq.pop_front();
        results_checked++;
        if (out_in_phase !== want.in_phase) begin
          $error("in_phase mismatch: expected %0d, got %0d", want.in_phase, out_in_phase);
          mismatches++;
        end
        if (out_quadrature !== want.quadrature) begin
          $error("quadrature mismatch: expected %0d, got %0d", want.quadrature, out_quadrature);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, pending_iq.size());
      $display("** ssb_hilbert_modulator_core: FAILED **");
      $finish;
    end
  end

  initial begin
    build_tap_rom();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_sideband(1'b0);
    test_directed_edges();
    test_saturation();
    write_sideband(1'b1);
    test_saturation();
    test_random_stream(500);
    test_backpressure();
    write_sideband(1'b0);
    test_random_stream(600);
    write_sideband(1'b1);
    test_random_stream(300);
    wait_idle();
    if (pending_iq.size() != 0) begin
      $error("%0d expected results never arrived", pending_iq.size());
      mismatches++;
    end
    $display("%0d samples sent, %0d I/Q results checked, %0d-tap filter", samples_sent,
             results_checked, NTAP);
    $display("both sidebands, saturation both ways, random stalls and a full-pipe hold-off");
    if (mismatches == 0) begin
      $display("** ssb_hilbert_modulator_core: PASSED **");
    end else begin
      $display("** ssb_hilbert_modulator_core: FAILED **");
    end
    $finish;
  end

endmodule
